>>> rtl/core/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator: character
// codes, the command passed from the front to the back and the result beat.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam int FLAG_DIV0  = 0;
  localparam int FLAG_DROP  = 1;
  localparam int FLAG_EMPTY = 2;
  localparam int FLAG_W     = 3;

  localparam int CMD_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_DIGIT = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_OTHER = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        div0;
    logic        drop;
    logic        empty;
  } res_t;

endpackage

>>> rtl/core/pee_fifo.sv
// ----------------------------------------------------------------------------
// pee_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module pee_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/pee_front.sv
// ----------------------------------------------------------------------------
// pee_front
// Classifies an expression character into a stack command.
// ----------------------------------------------------------------------------
module pee_front (
  input  logic          [7:0] char_code,
  input  logic                last_char,
  output pee_pkg::cmd_t       cmd
);

  logic [7:0] digit_off;

  assign digit_off = char_code - pee_pkg::CHAR_0;

  always_comb begin
    cmd.digit = digit_off[3:0];
    cmd.last  = last_char;
    if (char_code >= pee_pkg::CHAR_0 && char_code <= pee_pkg::CHAR_9) begin
      cmd.op = pee_pkg::OP_DIGIT;
    end else begin
      case (char_code)
        pee_pkg::CHAR_PLUS:  cmd.op = pee_pkg::OP_ADD;
        pee_pkg::CHAR_MINUS: cmd.op = pee_pkg::OP_SUB;
        pee_pkg::CHAR_STAR:  cmd.op = pee_pkg::OP_MUL;
        pee_pkg::CHAR_SLASH: cmd.op = pee_pkg::OP_DIV;
        default:             cmd.op = pee_pkg::OP_OTHER;
      endcase
    end
  end

endmodule

>>> rtl/core/pee_div.sv
// ----------------------------------------------------------------------------
// pee_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module pee_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] d_r;
  logic        neg_r;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    magnitude = v[31] ? (32'd0 - v) : v;
  endfunction

  assign rem_sh   = {rem_r[31:0], q_r[31]};
  assign diff     = rem_sh - {1'b0, d_r};
  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - q_r) : q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= magnitude(dividend);
      d_r   <= magnitude(divisor);
      rem_r <= '0;
      neg_r <= dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff;
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/pee_back.sv
// ----------------------------------------------------------------------------
// pee_back
// Stack engine: executes commands against the value stack memory, runs the
// arithmetic and emits the final result with sticky flags.
// ----------------------------------------------------------------------------
module pee_back #(
  parameter int STACK_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  pee_pkg::cmd_t cmd,
  input  logic          res_full,
  output logic          res_push,
  output pee_pkg::res_t res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDR  = 8'b0000_0010,
    S_RDL  = 8'b0000_0100,
    S_EXE  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_PUSH = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_FIN2 = 8'b1000_0000
  } state_t;

  state_t                        state_r,   state_nxt;
  pee_pkg::cmd_t                 cmd_r,     cmd_nxt;
  logic [CW-1:0]                 count_r,   count_nxt;
  logic [pee_pkg::FLAG_W-1:0]    flags_r,   flags_nxt;
  logic [31:0]                   right_r,   right_nxt;
  logic                          r_empty_r, r_empty_nxt;
  logic                          l_empty_r, l_empty_nxt;
  logic [31:0]                   res_r,     res_nxt;

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data_r;
  logic        mem_we;
  logic [31:0] mem_wdata;
  logic [CW-1:0] cnt_dec;
  logic        stk_full;
  logic        stk_empty;
  logic [31:0] left_v;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;

  assign cnt_dec   = count_r - CW'(1);
  assign stk_full  = (count_r == CW'(STACK_DEPTH));
  assign stk_empty = (count_r == '0);
  assign left_v    = l_empty_r ? '1 : rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= mem_wdata;
    end
    rd_data_r <= mem[cnt_dec[AW-1:0]];
  end

  pee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (left_v),
    .divisor  (right_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    count_nxt   = count_r;
    flags_nxt   = flags_r;
    right_nxt   = right_r;
    r_empty_nxt = r_empty_r;
    l_empty_nxt = l_empty_r;
    res_nxt     = res_r;
    cmd_pop     = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = res_r;
    div_start   = 1'b0;
    res_push    = 1'b0;
    res.value   = stk_empty ? '1 : rd_data_r;
    res.div0    = flags_r[pee_pkg::FLAG_DIV0];
    res.drop    = flags_r[pee_pkg::FLAG_DROP];
    res.empty   = flags_r[pee_pkg::FLAG_EMPTY] | stk_empty;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          if (cmd.op == pee_pkg::OP_DIGIT) begin
            mem_wdata = {28'd0, cmd.digit};
            if (stk_full) begin
              flags_nxt[pee_pkg::FLAG_DROP] = 1'b1;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            state_nxt = cmd.last ? S_FIN : S_IDLE;
          end else begin
            state_nxt = S_RDR;
          end
        end
      end
      S_RDR: begin
        r_empty_nxt = stk_empty;
        if (stk_empty) begin
          flags_nxt[pee_pkg::FLAG_EMPTY] = 1'b1;
        end else begin
          count_nxt = cnt_dec;
        end
        state_nxt = S_RDL;
      end
      S_RDL: begin
        right_nxt   = r_empty_r ? '1 : rd_data_r;
        l_empty_nxt = stk_empty;
        if (stk_empty) begin
          flags_nxt[pee_pkg::FLAG_EMPTY] = 1'b1;
        end else begin
          count_nxt = cnt_dec;
        end
        state_nxt = S_EXE;
      end
      S_EXE: begin
        case (cmd_r.op)
          pee_pkg::OP_ADD: begin
            res_nxt   = left_v + right_r;
            state_nxt = S_PUSH;
          end
          pee_pkg::OP_SUB: begin
            res_nxt   = left_v - right_r;
            state_nxt = S_PUSH;
          end
          pee_pkg::OP_MUL: begin
            res_nxt   = left_v * right_r;
            state_nxt = S_PUSH;
          end
          pee_pkg::OP_DIV: begin
            if (right_r == '0) begin
              res_nxt                       = '0;
              flags_nxt[pee_pkg::FLAG_DIV0] = 1'b1;
              state_nxt                     = S_PUSH;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: begin
            state_nxt = cmd_r.last ? S_FIN : S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = div_q;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stk_full) begin
          flags_nxt[pee_pkg::FLAG_DROP] = 1'b1;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        state_nxt = cmd_r.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        if (!res_full) begin
          res_push  = 1'b1;
          count_nxt = '0;
          flags_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    right_r   <= right_nxt;
    r_empty_r <= r_empty_nxt;
    l_empty_r <= l_empty_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      flags_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

>>> rtl/core/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix integer expressions fed one ASCII character per beat and
// returns the value with sticky error flags after the last character.
// ----------------------------------------------------------------------------
// A digit is pushed straight from the idle state of the stack engine; +, -
// and * take two stack reads (the stack memory has one read port), execute
// and push; / also waits in the divide state for the iterative divider. Any
// other character pops two operands and discards them. The last character
// adds the final pop. A four-entry command queue decouples input beats from
// the stack engine, and a two-entry result queue holds results until popped,
// so input keeps flowing while a result waits. An empty pop yields -1,
// pushes onto a full stack are dropped, division by zero pushes 0, and
// arithmetic wraps at 32 bits; the stack and flags clear after each result.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic        [7:0]  in_char_code,
  input  logic               in_last_char,
  input  logic               out_pop,
  output logic               out_empty,
  output logic signed [31:0] out_result_value,
  output logic               out_divide_by_zero,
  output logic               out_push_dropped,
  output logic               out_popped_empty
);

  pee_pkg::cmd_t front_cmd;
  pee_pkg::cmd_t back_cmd;
  logic [$bits(pee_pkg::cmd_t)-1:0] cmd_rdata;
  logic          cmd_empty;
  logic          cmd_pop;
  pee_pkg::res_t back_res;
  pee_pkg::res_t out_res;
  logic [$bits(pee_pkg::res_t)-1:0] res_rdata;
  logic          res_full;
  logic          res_push;

  pee_front u_front (
    .char_code (in_char_code),
    .last_char (in_last_char),
    .cmd       (front_cmd)
  );

  pee_fifo #(
    .WIDTH ($bits(pee_pkg::cmd_t)),
    .DEPTH (pee_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (front_cmd),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_rdata)
  );

  assign back_cmd = pee_pkg::cmd_t'(cmd_rdata);

  pee_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (back_cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  pee_fifo #(
    .WIDTH ($bits(pee_pkg::res_t)),
    .DEPTH (pee_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (back_res),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (res_rdata)
  );

  assign out_res            = pee_pkg::res_t'(res_rdata);
  assign out_result_value   = out_res.value;
  assign out_divide_by_zero = out_res.div0;
  assign out_push_dropped   = out_res.drop;
  assign out_popped_empty   = out_res.empty;

endmodule

>>> verif/tb_postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Feeds postfix expressions one character per beat. A directed table covers
// the empty stack, the full stack, division by zero and unknown characters.
// Random expressions follow: well-formed ones, corrupted ones, overflow
// chains, stack floods and plain noise. Every result beat is checked against
// the table or a stack predictor, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;

  localparam int DEPTH       = 128;
  localparam int TOTAL_BEATS = 1350;
  localparam int QUIET_BEATS = 1150;
  localparam int DRAIN_BEATS = 700;
  localparam int TAIL_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] ARITH_OPS [4] = '{pee_pkg::CHAR_PLUS, pee_pkg::CHAR_MINUS,
                                           pee_pkg::CHAR_STAR, pee_pkg::CHAR_SLASH};

  typedef struct packed {
    logic [7:0]    ch;
    logic          last;
    logic [7:0]    reps;
    logic          typed;
    pee_pkg::res_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic        [7:0]  in_char_code;
  logic               in_last_char;
  logic               out_pop = 1'b0;
  logic               out_empty;
  logic signed [31:0] out_result_value;
  logic               out_divide_by_zero;
  logic               out_push_dropped;
  logic               out_popped_empty;

  logic [31:0]                eval_stack [DEPTH];
  int                         eval_depth = 0;
  logic [pee_pkg::FLAG_W-1:0] eval_flags = '0;
  pee_pkg::res_t              pending_results [$];
  logic [7:0]                 expr_chars [$];
  dir_row_t                   directed_rows [25];
  int                         beats_sent = 0;
  int                         mismatch_count = 0;
  int                         push_gap_pct = 0;
  int                         pop_stall_pct = 5;
  int                         pop_hold = 0;
  int                         cycle_count = 0;
  bit                         quiet = 1'b0;

  postfix_expression_evaluator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_char_code       (in_char_code),
    .in_last_char       (in_last_char),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_result_value   (out_result_value),
    .out_divide_by_zero (out_divide_by_zero),
    .out_push_dropped   (out_push_dropped),
    .out_popped_empty   (out_popped_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pee_pkg::op_t char_op(input logic [7:0] c);
    if (c >= pee_pkg::CHAR_0 && c <= pee_pkg::CHAR_9) return pee_pkg::OP_DIGIT;
    case (c)
      pee_pkg::CHAR_PLUS:  return pee_pkg::OP_ADD;
      pee_pkg::CHAR_MINUS: return pee_pkg::OP_SUB;
      pee_pkg::CHAR_STAR:  return pee_pkg::OP_MUL;
      pee_pkg::CHAR_SLASH: return pee_pkg::OP_DIV;
      default:             return pee_pkg::OP_OTHER;
    endcase
  endfunction

  function automatic void stack_push(input logic [31:0] v);
    if (eval_depth >= DEPTH) begin
      eval_flags[pee_pkg::FLAG_DROP] = 1'b1;
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  function automatic logic [31:0] stack_pop();
    if (eval_depth == 0) begin
      eval_flags[pee_pkg::FLAG_EMPTY] = 1'b1;
      return '1;
    end
    eval_depth--;
    return eval_stack[eval_depth];
  endfunction

  function automatic logic [31:0] div_trunc(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [31:0] q;
    if (den == '0) begin
      eval_flags[pee_pkg::FLAG_DIV0] = 1'b1;
      return '0;
    end
    num_mag = num[31] ? -num : num;
    den_mag = den[31] ? -den : den;
    q = num_mag / den_mag;
    return (num[31] ^ den[31]) ? -q : q;
  endfunction

  task automatic evaluate_char(input logic [7:0] c, input logic last,
                               output bit done, output pee_pkg::res_t r);
    logic [31:0]  rhs;
    logic [31:0]  lhs;
    pee_pkg::op_t op;
    op = char_op(c);
    done = 1'b0;
    r = '0;
    if (op == pee_pkg::OP_DIGIT) begin
      stack_push({24'd0, c - pee_pkg::CHAR_0});
    end else begin
      rhs = stack_pop();
      lhs = stack_pop();
      case (op)
        pee_pkg::OP_ADD: stack_push(lhs + rhs);
        pee_pkg::OP_SUB: stack_push(lhs - rhs);
        pee_pkg::OP_MUL: stack_push(lhs * rhs);
        pee_pkg::OP_DIV: stack_push(div_trunc(lhs, rhs));
        default: ;
      endcase
    end
    if (last) begin
      r.value = stack_pop();
      r.div0  = eval_flags[pee_pkg::FLAG_DIV0];
      r.drop  = eval_flags[pee_pkg::FLAG_DROP];
      r.empty = eval_flags[pee_pkg::FLAG_EMPTY];
      eval_depth = 0;
      eval_flags = '0;
      done = 1'b1;
    end
  endtask

  task automatic send_beat(input logic [7:0] c, input logic last,
                           input logic typed, input pee_pkg::res_t typed_res);
    bit            done;
    pee_pkg::res_t r;
    if (!quiet && $urandom_range(0, 99) < push_gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    evaluate_char(c, last, done, r);
    if (done) pending_results.push_back(typed ? typed_res : r);
    beats_sent++;
  endtask

  task automatic send_expr();
    foreach (expr_chars[i]) send_beat(expr_chars[i], i == expr_chars.size() - 1, 1'b0, '0);
    expr_chars.delete();
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    pee_pkg::res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result beat: value %0d flags %b%b%b", $time,
               out_result_value, out_divide_by_zero, out_push_dropped, out_popped_empty);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      if (out_result_value !== want.value) begin
        $display("%0t: result_value expected %0d actual %0d", $time,
                 $signed(want.value), out_result_value);
        mismatch_count++;
      end
      if (out_divide_by_zero !== want.div0) begin
        $display("%0t: divide_by_zero expected %b actual %b", $time,
                 want.div0, out_divide_by_zero);
        mismatch_count++;
      end
      if (out_push_dropped !== want.drop) begin
        $display("%0t: push_dropped expected %b actual %b", $time,
                 want.drop, out_push_dropped);
        mismatch_count++;
      end
      if (out_popped_empty !== want.empty) begin
        $display("%0t: popped_empty expected %b actual %b", $time,
                 want.empty, out_popped_empty);
        mismatch_count++;
      end
    end
  endtask

  // result side: accept, then choose the next pop with random stall bursts
  always @(posedge clk) begin
    if (out_pop && !out_empty) check_result();
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
    end else if (!quiet && $urandom_range(0, 99) < pop_stall_pct) begin
      out_pop  <= 1'b0;
      pop_hold <= $urandom_range(0, 11);
    end else begin
      out_pop <= 1'b1;
    end
    if ($urandom_range(0, 255) == 0) begin
      case ($urandom_range(0, 2))
        0:       pop_stall_pct <= 0;
        1:       pop_stall_pct <= 5;
        default: pop_stall_pct <= 30;
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    dir_row_t    row;
    int unsigned n;
    int unsigned left;
    int unsigned depth;
    int unsigned kind;
    bit          drained;
    rst_n        <= 1'b0;
    in_push      <= 1'b0;
    in_char_code <= '0;
    in_last_char <= 1'b0;
    drained = 1'b0;
    directed_rows = '{
      '{pee_pkg::CHAR_PLUS,          1'b1, 8'd1,   1'b1, '{32'hFFFF_FFFE, 1'b0, 1'b0, 1'b1}},
      '{pee_pkg::CHAR_0,             1'b1, 8'd1,   1'b1, '{32'd0,         1'b0, 1'b0, 1'b0}},
      '{pee_pkg::CHAR_9,             1'b1, 8'd1,   1'b1, '{32'd9,         1'b0, 1'b0, 1'b0}},
      '{8'(pee_pkg::CHAR_0 + 8'd8),  1'b0, 8'd1,   1'b0, '0},
      '{pee_pkg::CHAR_0,             1'b0, 8'd1,   1'b0, '0},
      '{pee_pkg::CHAR_SLASH,         1'b1, 8'd1,   1'b1, '{32'd0,         1'b1, 1'b0, 1'b0}},
      '{pee_pkg::CHAR_9,             1'b0, 8'd2,   1'b0, '0},
      '{pee_pkg::CHAR_STAR,          1'b1, 8'd1,   1'b1, '{32'd81,        1'b0, 1'b0, 1'b0}},
      '{8'(pee_pkg::CHAR_0 + 8'd3),  1'b0, 8'd1,   1'b0, '0},
      '{8'(pee_pkg::CHAR_0 + 8'd7),  1'b0, 8'd1,   1'b0, '0},
      '{pee_pkg::CHAR_MINUS,         1'b1, 8'd1,   1'b1, '{32'hFFFF_FFFC, 1'b0, 1'b0, 1'b0}},
      '{8'h61,                       1'b1, 8'd1,   1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1}},
      '{8'h00,                       1'b0, 8'd1,   1'b0, '0},
      '{8'hFF,                       1'b1, 8'd1,   1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1}},
      '{pee_pkg::CHAR_9,             1'b0, 8'd130, 1'b0, '0},
      '{pee_pkg::CHAR_PLUS,          1'b1, 8'd1,   1'b1, '{32'd18,        1'b0, 1'b1, 1'b0}},
      '{8'(pee_pkg::CHAR_0 + 8'd5),  1'b0, 8'd1,   1'b0, '0},
      '{pee_pkg::CHAR_PLUS,          1'b1, 8'd1,   1'b1, '{32'd4,         1'b0, 1'b0, 1'b1}},
      '{pee_pkg::CHAR_0,             1'b0, 8'd1,   1'b0, '0},
      '{8'(pee_pkg::CHAR_0 + 8'd7),  1'b0, 8'd1,   1'b0, '0},
      '{pee_pkg::CHAR_MINUS,         1'b0, 8'd1,   1'b0, '0},
      '{8'(pee_pkg::CHAR_0 + 8'd2),  1'b0, 8'd1,   1'b0, '0},
      '{pee_pkg::CHAR_SLASH,         1'b1, 8'd1,   1'b0, '0},
      '{8'(pee_pkg::CHAR_0 + 8'd4),  1'b0, 8'd3,   1'b0, '0},
      '{pee_pkg::CHAR_STAR,          1'b1, 8'd1,   1'b1, '{32'd16,        1'b0, 1'b0, 1'b0}}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      repeat (row.reps) send_beat(row.ch, row.last, row.typed, row.want);
    end
    drain_results();

    while (beats_sent < TOTAL_BEATS) begin
      quiet = (beats_sent >= QUIET_BEATS);
      case ($urandom_range(0, 3))
        0:       push_gap_pct = 0;
        1:       push_gap_pct = 5;
        2:       push_gap_pct = 20;
        default: push_gap_pct = 50;
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        left = n;
        depth = 0;
        while (left > 0 || depth > 1) begin
          if (depth >= 2 && (left == 0 || $urandom_range(0, 1) == 1)) begin
            expr_chars.push_back(ARITH_OPS[$urandom_range(0, 3)]);
            depth--;
          end else begin
            expr_chars.push_back(8'(pee_pkg::CHAR_0 + $urandom_range(0, 9)));
            depth++;
            left--;
          end
        end
        // corrupt one character of some expressions
        if (kind >= 60)
          expr_chars[$urandom_range(0, expr_chars.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 80) begin
        if ($urandom_range(0, 1) == 1) begin
          expr_chars.push_back(pee_pkg::CHAR_0);
          expr_chars.push_back(8'(pee_pkg::CHAR_0 + $urandom_range(1, 9)));
          expr_chars.push_back(pee_pkg::CHAR_MINUS);
        end else begin
          expr_chars.push_back(8'(pee_pkg::CHAR_0 + $urandom_range(1, 9)));
        end
        repeat ($urandom_range(6, 16)) begin
          expr_chars.push_back(8'(pee_pkg::CHAR_0 + $urandom_range(2, 9)));
          expr_chars.push_back(($urandom_range(0, 3) == 0) ?
                               ARITH_OPS[$urandom_range(0, 1)] : pee_pkg::CHAR_STAR);
        end
      end else if (kind < 85) begin
        // build the most negative value, then divide or multiply it by minus one
        expr_chars.push_back(8'(pee_pkg::CHAR_0 + 8'd2));
        repeat (10) begin
          expr_chars.push_back(8'(pee_pkg::CHAR_0 + 8'd8));
          expr_chars.push_back(pee_pkg::CHAR_STAR);
        end
        expr_chars.push_back(pee_pkg::CHAR_0);
        expr_chars.push_back(8'(pee_pkg::CHAR_0 + 8'd1));
        expr_chars.push_back(pee_pkg::CHAR_MINUS);
        expr_chars.push_back(($urandom_range(0, 1) == 1) ?
                             pee_pkg::CHAR_SLASH : pee_pkg::CHAR_STAR);
      end else if (kind < 87) begin
        repeat ($urandom_range(DEPTH - 2, DEPTH + 6))
          expr_chars.push_back(8'(pee_pkg::CHAR_0 + $urandom_range(0, 9)));
        repeat ($urandom_range(1, 4)) expr_chars.push_back(ARITH_OPS[$urandom_range(0, 3)]);
      end else begin
        repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
      end
      send_expr();
      if (!drained && beats_sent >= DRAIN_BEATS) begin
        drain_results();
        drained = 1'b1;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
